@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside of reset.
`define ACE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ACE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/ace_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ace_pkg;

  localparam int SampleWidth = 16;
  localparam int ScaledWidth = 24;
  localparam int DepthWidth  = 5;
  localparam int AlphaWidth  = 8;

  localparam logic [2:0] MODE_PLANAR8  = 3'd0;
  localparam logic [2:0] MODE_PLANAR10 = 3'd1;
  localparam logic [2:0] MODE_PLANAR16 = 3'd2;
  localparam logic [2:0] MODE_RGBA8    = 3'd3;
  localparam logic [2:0] MODE_RGBA64   = 3'd4;
  localparam logic [2:0] MODE_GENERIC  = 3'd5;
  localparam logic [2:0] MODE_NONE     = 3'd6;

  localparam logic [1:0] CFG_FORMAT_MODE   = 2'd0;
  localparam logic [1:0] CFG_ALPHA_DEPTH   = 2'd1;
  localparam logic [1:0] CFG_ALPHA_PRESENT = 2'd2;

  localparam logic [AlphaWidth-1:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [ScaledWidth-1:0] scaled;
    logic [SampleWidth-1:0] mask;
    logic [DepthWidth-1:0]  depth;
  } ace_div_in_t;

endpackage

`default_nettype wire

@@ hdl/ace_div_mersenne.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Divides by 2^depth - 1 for depths of 9 to 16. The quotient is below 256, so
// folding the high part onto the low part needs at most one correction.
module ace_div_mersenne (
  input  var ace_pkg::ace_div_in_t   div_in,
  output logic [ace_pkg::AlphaWidth-1:0] quotient
);

  logic [ace_pkg::ScaledWidth-1:0] shifted;
  logic [ace_pkg::AlphaWidth-1:0]  q_low;
  logic [ace_pkg::SampleWidth-1:0] r_low;
  logic [ace_pkg::SampleWidth:0]   fold_sum;
  logic                            carry;

  assign shifted  = div_in.scaled >> div_in.depth;
  assign q_low    = shifted[ace_pkg::AlphaWidth-1:0];
  assign r_low    = div_in.scaled[ace_pkg::SampleWidth-1:0] & div_in.mask;
  assign fold_sum = {9'd0, q_low} + {1'b0, r_low};
  assign carry    = (fold_sum >= {1'b0, div_in.mask});
  assign quotient = q_low + {7'd0, carry};

endmodule

`default_nettype wire

@@ hdl/alpha_channel_extractor_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Payload
// input     in_valid/in_stall   pixel_word[63:0]
// output    out_valid/out_stall alpha_out[7:0]
// config    cfg_valid/cfg_ready cfg_index[1:0], cfg_data[4:0]
//
// Every transaction passes from input to output through one registered stage per step:
// decode, scale by 255 with rounding bias, divide by the sample maximum or pass a direct byte.
// A new pixel can enter on every clock that in_stall is low.
// The whole pipeline holds while the output is valid and stalled.
// Reset empties the pipeline and loads mode 0, depth 8, alpha present.
// The configuration port is always ready.
module alpha_channel_extractor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] pixel_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  alpha_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  logic [2:0] format_mode;
  logic [4:0] alpha_depth;
  logic       alpha_present;

  logic        advance;
  logic [15:0] sample;
  logic [4:0]  depth_clamped;
  logic [15:0] generic_mask;

  logic        s1_direct_next;
  logic [7:0]  s1_byte_next;
  logic [15:0] s1_mask_next;
  logic [4:0]  s1_depth_next;
  logic        s1_round_next;

  logic        s1_valid;
  logic        s1_direct;
  logic [7:0]  s1_byte;
  logic [15:0] s1_sample;
  logic [15:0] s1_mask;
  logic [4:0]  s1_depth;
  logic        s1_round;

  logic [23:0] s2_scaled_next;
  logic        s2_valid;
  logic        s2_direct;
  logic [7:0]  s2_byte;
  ace_pkg::ace_div_in_t s2_div;

  logic [7:0] quotient;

  assign cfg_ready = 1'b1;
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode   <= ace_pkg::MODE_PLANAR8;
      alpha_depth   <= 5'd8;
      alpha_present <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ace_pkg::CFG_FORMAT_MODE:   format_mode   <= cfg_data[2:0];
        ace_pkg::CFG_ALPHA_DEPTH:   alpha_depth   <= cfg_data;
        ace_pkg::CFG_ALPHA_PRESENT: alpha_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign sample = pixel_word[15:0];

  always_comb begin
    if (alpha_depth == 5'd0) begin
      depth_clamped = 5'd1;
    end else if (alpha_depth > 5'd16) begin
      depth_clamped = 5'd16;
    end else begin
      depth_clamped = alpha_depth;
    end
  end

  assign generic_mask = 16'hFFFF >> (5'd16 - depth_clamped);

  always_comb begin
    s1_direct_next = 1'b1;
    s1_byte_next   = ace_pkg::ALPHA_OPAQUE;
    s1_mask_next   = 16'h03FF;
    s1_depth_next  = 5'd10;
    s1_round_next  = 1'b1;
    if (alpha_present) begin
      case (format_mode)
        ace_pkg::MODE_PLANAR8: begin
          if (sample <= 16'd255) begin
            s1_byte_next = sample[7:0];
          end
        end
        ace_pkg::MODE_PLANAR10: begin
          if (sample <= 16'd1023) begin
            s1_direct_next = 1'b0;
          end
        end
        ace_pkg::MODE_PLANAR16: s1_byte_next = sample[15:8];
        ace_pkg::MODE_RGBA8:    s1_byte_next = pixel_word[31:24];
        ace_pkg::MODE_RGBA64:   s1_byte_next = pixel_word[63:56];
        ace_pkg::MODE_GENERIC: begin
          s1_mask_next  = generic_mask;
          s1_depth_next = depth_clamped;
          s1_round_next = 1'b0;
          if (sample <= generic_mask) begin
            if (depth_clamped <= 5'd8) begin
              s1_byte_next = sample[7:0];
            end else begin
              s1_direct_next = 1'b0;
            end
          end
        end
        default: s1_byte_next = ace_pkg::ALPHA_OPAQUE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_direct <= s1_direct_next;
      s1_byte   <= s1_byte_next;
      s1_sample <= sample;
      s1_mask   <= s1_mask_next;
      s1_depth  <= s1_depth_next;
      s1_round  <= s1_round_next;
    end
  end

  assign s2_scaled_next = ({8'd0, s1_sample} << 8) - {8'd0, s1_sample}
                        + {9'd0, s1_mask[15:1]} + {23'd0, s1_round};

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_direct     <= s1_direct;
      s2_byte       <= s1_byte;
      s2_div.scaled <= s2_scaled_next;
      s2_div.mask   <= s1_mask;
      s2_div.depth  <= s1_depth;
    end
  end

  ace_div_mersenne u_div (
    .div_in   (s2_div),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      alpha_out <= s2_direct ? s2_byte : quotient;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ace_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ace_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] alpha_out
);

  logic in_accept;
  logic out_hold;

  assign in_accept = in_valid && !in_stall;
  assign out_hold  = out_valid && out_stall;

  `ACE_ASSERT(a_out_hold, out_hold |=> out_valid && $stable(alpha_out), "stalled output changed")
  `ACE_ASSERT(a_stall_cause, in_stall == out_hold, "input stall without a stalled output")
  `ACE_ASSERT(a_latency, in_accept ##1 !in_stall ##1 !in_stall |=> out_valid, "late output")
  `ACE_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "output valid right after reset")

endmodule

bind alpha_channel_extractor_top ace_checker u_ace_checker (.*);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

class alpha_ledger;
  logic [2:0] mode;
  logic [4:0] depth;
  logic       present;
  logic [7:0] expected_alpha[$];
  int         errors;

  function new();
    mode    = ace_pkg::MODE_PLANAR8;
    depth   = 5'd8;
    present = 1'b1;
    errors  = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [4:0] data);
    case (idx)
      ace_pkg::CFG_FORMAT_MODE: begin
        mode = data[2:0];
      end
      ace_pkg::CFG_ALPHA_DEPTH: begin
        depth = data;
      end
      ace_pkg::CFG_ALPHA_PRESENT: begin
        present = data[0];
      end
      default: begin
      end
    endcase
  endfunction

  function logic [7:0] predict_alpha(logic [63:0] word);
    int v;
    int d;
    int top;
    v = word[15:0];
    if (!present) begin
      return ace_pkg::ALPHA_OPAQUE;
    end
    case (mode)
      ace_pkg::MODE_PLANAR8: begin
        return (v > 255) ? ace_pkg::ALPHA_OPAQUE : word[7:0];
      end
      ace_pkg::MODE_PLANAR10: begin
        return (v > 1023) ? ace_pkg::ALPHA_OPAQUE : 8'((v * 255 + 512) / 1023);
      end
      ace_pkg::MODE_PLANAR16: begin
        return word[15:8];
      end
      ace_pkg::MODE_RGBA8: begin
        return word[31:24];
      end
      ace_pkg::MODE_RGBA64: begin
        return word[63:56];
      end
      ace_pkg::MODE_GENERIC: begin
        d = depth;
        if (d < 1) begin
          d = 1;
        end
        if (d > 16) begin
          d = 16;
        end
        top = (1 << d) - 1;
        if (v > top) begin
          return ace_pkg::ALPHA_OPAQUE;
        end
        if (d <= 8) begin
          return word[7:0];
        end
        return 8'((v * 255 + top / 2) / top);
      end
      default: begin
        return ace_pkg::ALPHA_OPAQUE;
      end
    endcase
  endfunction

  function void note_pixel(logic [63:0] word);
    expected_alpha.push_back(predict_alpha(word));
  endfunction

  function void check_alpha(logic [7:0] actual);
    logic [7:0] want;
    if (expected_alpha.size() == 0) begin
      $display("%0t: alpha %0d arrived with no transaction pending", $time, actual);
      errors++;
    end else begin
      want = expected_alpha.pop_front();
      if (actual !== want) begin
        $display("%0t: alpha_out mismatch, expected %0d actual %0d", $time, want, actual);
        errors++;
      end
    end
  endfunction
endclass

module testbench;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int CycleLimit = 100000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] pixel_word = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  alpha_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [4:0]  cfg_data = 5'd0;
  logic        calm = 1'b0;
  int          cycles = 0;
  alpha_ledger ledger;

  alpha_channel_extractor_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_word (pixel_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .alpha_out  (alpha_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      ledger.check_alpha(alpha_out);
    end
  end

  task automatic send_pixel(input logic [63:0] word);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    pixel_word <= word;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    ledger.note_pixel(word);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    ledger.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Registers change only once the pipeline has drained.
  task automatic set_config(input logic [2:0] mode, input logic [4:0] depth,
                            input logic present);
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.expected_alpha.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    write_reg(ace_pkg::CFG_FORMAT_MODE, {2'b00, mode});
    write_reg(ace_pkg::CFG_ALPHA_DEPTH, depth);
    write_reg(ace_pkg::CFG_ALPHA_PRESENT, {4'd0, present});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          phase;
    int          n;
    int          pick;
    int          top;
    int          d;
    logic [2:0]  mode;
    logic [4:0]  depth;
    logic [63:0] word;

    ledger = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_pixel(64'd0);
    send_pixel(64'd255);
    send_pixel(64'd256);
    send_pixel({64{1'b1}});

    set_config(ace_pkg::MODE_PLANAR10, 5'd8, 1'b1);
    send_pixel(64'd1);
    send_pixel(64'd511);
    send_pixel(64'd1023);
    send_pixel(64'd1024);

    set_config(ace_pkg::MODE_PLANAR16, 5'd8, 1'b1);
    send_pixel(64'h0000_0000_0000_FF00);
    send_pixel(64'hFFFF_FFFF_FFFF_00FF);

    set_config(ace_pkg::MODE_RGBA8, 5'd8, 1'b1);
    @(negedge clk);
    write_reg(CFG_UNUSED, 5'h1F);
    cfg_valid <= 1'b0;
    send_pixel(64'hFFFF_FFFF_5AFF_FFFF);
    send_pixel(64'h0000_0000_A500_0000);

    set_config(ace_pkg::MODE_RGBA64, 5'd8, 1'b1);
    send_pixel(64'hC3FF_FFFF_FFFF_FFFF);
    send_pixel(64'h3C00_0000_0000_0000);

    set_config(ace_pkg::MODE_GENERIC, 5'd0, 1'b1);
    send_pixel(64'd1);
    send_pixel(64'd2);

    set_config(ace_pkg::MODE_GENERIC, 5'd9, 1'b1);
    send_pixel(64'd256);
    send_pixel(64'd511);
    send_pixel(64'd512);

    set_config(ace_pkg::MODE_GENERIC, 5'd16, 1'b1);
    send_pixel(64'h0000_0000_0000_FFFF);
    send_pixel(64'h0000_0000_0000_8000);

    set_config(ace_pkg::MODE_GENERIC, 5'd31, 1'b1);
    send_pixel(64'h0000_0000_0000_7FFF);

    set_config(ace_pkg::MODE_NONE, 5'd8, 1'b1);
    send_pixel(64'd0);

    set_config(MODE_UNUSED, 5'd8, 1'b1);
    send_pixel({64{1'b1}});

    set_config(ace_pkg::MODE_RGBA8, 5'd8, 1'b0);
    send_pixel(64'd0);

    for (phase = 0; phase < 40; phase++) begin
      calm = (phase >= 12 && phase < 20);
      pick = $urandom_range(0, 19);
      mode = (pick < 18) ? 3'(pick % 6) : 3'(pick - 12);
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 6))
          0: depth = 5'd0;
          1: depth = 5'd1;
          2: depth = 5'd8;
          3: depth = 5'd9;
          4: depth = 5'd16;
          5: depth = 5'd17;
          default: depth = 5'd31;
        endcase
      end else begin
        depth = 5'($urandom_range(0, 31));
      end
      set_config(mode, depth, $urandom_range(0, 9) != 0);

      d = (depth < 1) ? 1 : (depth > 16) ? 16 : depth;
      case (mode)
        ace_pkg::MODE_PLANAR8: top = 255;
        ace_pkg::MODE_PLANAR10: top = 1023;
        ace_pkg::MODE_GENERIC: top = (1 << d) - 1;
        default: top = 65535;
      endcase

      for (n = 0; n < 46; n++) begin
        word = {$urandom, $urandom};
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: word[15:0] = 16'($urandom_range(0, top));
          6: word[15:0] = 16'(top);
          7: word[15:0] = 16'd0;
          8: begin
            if (top < 65535) begin
              word[15:0] = 16'(top + 1);
            end
          end
          default: begin
          end
        endcase
        send_pixel(word);
      end
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.expected_alpha.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
